@@ src/etl_pkg.sv @@
// Shared types for the expression token lexer: token kinds, token records
// and the entries passed from the scanner to the emitter queue.
// No dependencies.
package etl_pkg;

	// Token kinds as they appear on the result channel
	typedef enum logic [4:0] {
		KIND_END    = 5'd0,
		KIND_NUMBER = 5'd1,
		KIND_IDENT  = 5'd2,
		KIND_PLUS   = 5'd3,
		KIND_MINUS  = 5'd4,
		KIND_STAR   = 5'd5,
		KIND_SLASH  = 5'd6,
		KIND_CARET  = 5'd7,
		KIND_LPAREN = 5'd8,
		KIND_RPAREN = 5'd9,
		KIND_COMMA  = 5'd10,
		KIND_QUEST  = 5'd11,
		KIND_COLON  = 5'd12,
		KIND_LT     = 5'd13,
		KIND_LE     = 5'd14,
		KIND_GT     = 5'd15,
		KIND_GE     = 5'd16,
		KIND_EQ     = 5'd17,
		KIND_NE     = 5'd18,
		KIND_ERROR  = 5'd19
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
	} token_t;

	// One entry holds the one or two tokens of one scanned character
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} entry_t;

	// Entries between scanner and emitter (power of two)
	localparam int QUEUE_DEPTH = 4;

endpackage

@@ src/etl_front.sv @@
// Scanner front end: holds scan mode, character position and token start,
// and turns each accepted character into zero, one or two tokens.
// Depends on etl_pkg.
module etl_front #(
	parameter int MAX_SOURCE_LENGTH = 65535
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      char_code,
	input  logic            end_of_text,
	output logic            push,
	output etl_pkg::entry_t entry
);

	localparam int PW  = $clog2(MAX_SOURCE_LENGTH + 1);
	localparam int PWX = (PW > 16) ? PW : 16;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_SOURCE_LENGTH);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	typedef enum logic [3:0] {
		M_IDLE, M_INT, M_FRAC, M_IDENT, M_DOT, M_LT, M_GT, M_EQ, M_BANG, M_ERR
	} mode_t;

	mode_t           mode_q, mode_d;
	logic [PW-1:0]   pos_q, pos_d;
	logic [PW-1:0]   pstart_q, pstart_d;
	logic [PW-1:0]   diff;
	logic [PWX-1:0]  pos_x, pstart_x, len_x;
	logic [15:0]     pos16, pstart16, len16;
	logic [1:0]      n;
	etl_pkg::token_t tok0, tok1;

	// Character classes
	logic is_digit, is_alpha, is_word, is_space;
	logic idle_emit;
	mode_t idle_mode;
	etl_pkg::kind_t single;

	function automatic etl_pkg::kind_t single_kind(input logic [7:0] c);
		case (c)
			8'h2B:   single_kind = etl_pkg::KIND_PLUS;
			8'h2D:   single_kind = etl_pkg::KIND_MINUS;
			8'h2A:   single_kind = etl_pkg::KIND_STAR;
			8'h2F:   single_kind = etl_pkg::KIND_SLASH;
			8'h5E:   single_kind = etl_pkg::KIND_CARET;
			8'h28:   single_kind = etl_pkg::KIND_LPAREN;
			8'h29:   single_kind = etl_pkg::KIND_RPAREN;
			8'h2C:   single_kind = etl_pkg::KIND_COMMA;
			8'h3F:   single_kind = etl_pkg::KIND_QUEST;
			8'h3A:   single_kind = etl_pkg::KIND_COLON;
			default: single_kind = etl_pkg::KIND_END;
		endcase
	endfunction

	assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_alpha = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
	                  ((char_code >= 8'h61) && (char_code <= 8'h7A));
	assign is_word  = is_alpha || is_digit || (char_code == CH_US);
	assign is_space = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
	                  (char_code == CH_LF) || (char_code == CH_CR);
	assign single   = single_kind(char_code);

	// Low 16 bits of positions and pending length
	assign diff     = pos_q - pstart_q;
	assign pos_x    = PWX'(pos_q);
	assign pstart_x = PWX'(pstart_q);
	assign len_x    = PWX'(diff);
	assign pos16    = pos_x[15:0];
	assign pstart16 = pstart_x[15:0];
	assign len16    = len_x[15:0];

	// Scan of a character with nothing pending
	always_comb begin
		idle_emit = 1'b0;
		idle_mode = M_IDLE;
		if (is_digit) begin
			idle_mode = M_INT;
		end else if (char_code == CH_DOT) begin
			idle_mode = M_DOT;
		end else if (is_alpha || char_code == CH_US) begin
			idle_mode = M_IDENT;
		end else if (char_code == CH_LT) begin
			idle_mode = M_LT;
		end else if (char_code == CH_GT) begin
			idle_mode = M_GT;
		end else if (char_code == CH_EQ) begin
			idle_mode = M_EQ;
		end else if (char_code == CH_BANG) begin
			idle_mode = M_BANG;
		end else if (single != etl_pkg::KIND_END) begin
			idle_emit = 1'b1;
		end else begin
			idle_emit = 1'b1;
			idle_mode = M_ERR;
		end
	end

	// Mode transition and token generation
	always_comb begin
		logic           run_idle;
		etl_pkg::kind_t ik;
		run_idle = 1'b0;
		ik       = (single != etl_pkg::KIND_END) ? single : etl_pkg::KIND_ERROR;
		n        = 2'd0;
		tok0     = '0;
		tok1     = '0;
		mode_d   = mode_q;
		pos_d    = pos_q;
		pstart_d = pstart_q;
		if (end_of_text) begin
			// flush pending token, then END
			case (mode_q)
				M_INT, M_FRAC: begin
					tok0 = '{etl_pkg::KIND_NUMBER, pstart16, len16};
					n = 2'd1;
				end
				M_IDENT: begin
					tok0 = '{etl_pkg::KIND_IDENT, pstart16, len16};
					n = 2'd1;
				end
				M_LT: begin
					tok0 = '{etl_pkg::KIND_LT, pstart16, 16'd1};
					n = 2'd1;
				end
				M_GT: begin
					tok0 = '{etl_pkg::KIND_GT, pstart16, 16'd1};
					n = 2'd1;
				end
				M_DOT, M_EQ, M_BANG: begin
					tok0 = '{etl_pkg::KIND_ERROR, pstart16, 16'd0};
					n = 2'd1;
				end
				default: ;
			endcase
			if (n == 2'd1) begin
				tok1 = '{etl_pkg::KIND_END, pos16, 16'd0};
				n = 2'd2;
			end else begin
				tok0 = '{etl_pkg::KIND_END, pos16, 16'd0};
				n = 2'd1;
			end
			mode_d   = M_IDLE;
			pos_d    = '0;
			pstart_d = '0;
		end else begin
			if (pos_q < MAX_POS) begin
				pos_d = pos_q + PW'(1);
			end
			if (mode_q == M_ERR) begin
				// drop everything until end of text
			end else if (pos_q >= MAX_POS) begin
				mode_d = M_ERR;
				tok0 = '{etl_pkg::KIND_ERROR, pos16, 16'd0};
				n = 2'd1;
			end else begin
				case (mode_q)
					M_INT: begin
						if (char_code == CH_DOT) begin
							mode_d = M_FRAC;
						end else if (!is_digit) begin
							tok0 = '{etl_pkg::KIND_NUMBER, pstart16, len16};
							n = 2'd1;
							run_idle = 1'b1;
						end
					end
					M_FRAC: begin
						if (!is_digit) begin
							tok0 = '{etl_pkg::KIND_NUMBER, pstart16, len16};
							n = 2'd1;
							run_idle = 1'b1;
						end
					end
					M_IDENT: begin
						if (!is_word) begin
							tok0 = '{etl_pkg::KIND_IDENT, pstart16, len16};
							n = 2'd1;
							run_idle = 1'b1;
						end
					end
					M_DOT: begin
						if (is_digit) begin
							mode_d = M_FRAC;
						end else begin
							mode_d = M_ERR;
							tok0 = '{etl_pkg::KIND_ERROR, pstart16, 16'd0};
							n = 2'd1;
						end
					end
					M_LT, M_GT: begin
						n = 2'd1;
						if (char_code == CH_EQ) begin
							tok0.kind = (mode_q == M_LT) ? etl_pkg::KIND_LE : etl_pkg::KIND_GE;
							tok0.start = pstart16;
							tok0.length = 16'd2;
							mode_d = M_IDLE;
						end else begin
							tok0.kind = (mode_q == M_LT) ? etl_pkg::KIND_LT : etl_pkg::KIND_GT;
							tok0.start = pstart16;
							tok0.length = 16'd1;
							run_idle = 1'b1;
						end
					end
					M_EQ, M_BANG: begin
						n = 2'd1;
						if (char_code == CH_EQ) begin
							tok0.kind = (mode_q == M_EQ) ? etl_pkg::KIND_EQ : etl_pkg::KIND_NE;
							tok0.start = pstart16;
							tok0.length = 16'd2;
							mode_d = M_IDLE;
						end else begin
							tok0 = '{etl_pkg::KIND_ERROR, pstart16, 16'd0};
							mode_d = M_ERR;
						end
					end
					default: run_idle = 1'b1;
				endcase
				// the terminating character starts a new scan
				if (run_idle) begin
					mode_d = M_IDLE;
					if (!is_space) begin
						pstart_d = pos_q;
						mode_d = idle_mode;
						if (idle_emit) begin
							if (n == 2'd0) begin
								tok0 = '{ik, pos16, (ik == etl_pkg::KIND_ERROR) ? 16'd0 : 16'd1};
								n = 2'd1;
							end else begin
								tok1 = '{ik, pos16, (ik == etl_pkg::KIND_ERROR) ? 16'd0 : 16'd1};
								n = 2'd2;
							end
						end
					end
				end
			end
		end
	end

	assign push  = accept && (n != 2'd0);
	assign entry = '{(n == 2'd2), tok0, tok1};

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
		end
	end

endmodule

@@ src/etl_queue.sv @@
// Short queue of token entries between scanner and emitter.
// Depends on etl_pkg (entry type and depth).
module etl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  etl_pkg::entry_t wr_entry,
	input  logic            pop,
	output etl_pkg::entry_t head,
	output logic            head_valid,
	output logic            full
);

	localparam int AW = $clog2(etl_pkg::QUEUE_DEPTH);

	etl_pkg::entry_t mem_q [etl_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;

	assign full       = (count_q == (AW+1)'(etl_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/etl_back.sv @@
// Emitter back end: splits queued entries into single tokens and holds
// each in the output register until the receiver takes it.
// Depends on etl_pkg.
module etl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  etl_pkg::entry_t head,
	input  logic            head_valid,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [4:0]      token_kind,
	output logic [15:0]     token_start,
	output logic [15:0]     token_length,
	output logic            last_of_run
);

	logic            valid_q;
	logic            idx_q;
	logic            take;
	logic            last;
	etl_pkg::token_t sel;
	etl_pkg::token_t tok_q;
	logic            last_q;

	// Load when the output register is empty or being drained
	assign take = head_valid && (!valid_q || !out_stall);
	assign sel  = idx_q ? head.tok1 : head.tok0;
	assign last = !head.two || idx_q;
	assign pop  = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= !last;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= sel;
			last_q <= last;
		end
	end

	assign out_valid    = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.length;
	assign last_of_run  = last_q;

endmodule

@@ src/expression_token_lexer.sv @@
// Top level of the expression token lexer: scanner, entry queue, emitter.
// Depends on etl_pkg, etl_front, etl_queue, etl_back.
//
// Input channel: one ASCII character (char_code) or an end-of-text mark
// (end_of_text) per transfer, on in_valid / in_stall.
// Output channel: one token per transfer (kind, start, length) on
// out_valid / out_stall; last_of_run marks the final token of a character.
// Throughput: one character per cycle while the queue is not full. A
// character that yields two tokens leaves as two output transfers, so a
// long run of those halves the rate once the four-entry queue has filled.
// Characters that yield nothing push no entry. The edge that accepts a
// character writes its entry into the queue; the output register loads
// from the queue head when it is empty or being drained.
// The scan state updates on each accepted character; the queue depth
// and the output register set how far the input runs ahead of a stalled
// receiver. in_stall rises when the queue is full.
// Reset clears scan state, position, queue and output valid; no clearing
// pass is needed. End of text returns the scanner to its reset state.
module expression_token_lexer #(
	parameter int MAX_SOURCE_LENGTH = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic            accept;
	logic            push;
	logic            pop;
	logic            full;
	logic            head_valid;
	etl_pkg::entry_t wr_entry;
	etl_pkg::entry_t head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	etl_front #(
		.MAX_SOURCE_LENGTH(MAX_SOURCE_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.push       (push),
		.entry      (wr_entry)
	);

	etl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid),
		.full      (full)
	);

	etl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.last_of_run (last_of_run)
	);

endmodule
